>>> hdl/dmx_delta_group_packetizer_assert.svh
// Assertion macros for the DMX delta group packetizer.
// Needs nothing else; files that check their own logic include it.
// Define NO_ASSERTIONS to compile every use to nothing.
`ifndef DMX_DELTA_GROUP_PACKETIZER_ASSERT_SVH
`define DMX_DELTA_GROUP_PACKETIZER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication under asynchronous active-low reset.
`define DGP_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("dgp assertion failed");

// Next-cycle implication under asynchronous active-low reset.
`define DGP_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("dgp assertion failed");

`else

`define DGP_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define DGP_ASSERT_NXT(lbl, ck, rn, ante, cons)

`endif

`endif

>>> hdl/dgp_pkg.sv
// Shared types and constants for the DMX delta group packetizer.
// No dependencies; the front, queue, back and top-level files refer to it by scoped names.
`timescale 1ns / 1ps

package dgp_pkg;

	// Default geometry: groups of slots and number of groups
	localparam int unsigned GROUP_BYTES_DEF = 16;
	localparam int unsigned GROUP_COUNT_DEF = 32;

	// Field widths
	localparam int unsigned SLOT_W    = 9;
	localparam int unsigned LEVEL_W   = 8;
	localparam int unsigned TIMEOUT_W = 16;
	localparam int unsigned MS_W      = 17;
	localparam int unsigned SEQ_W     = 8;
	localparam int unsigned GROUP_OUT_W = 8;
	localparam int unsigned POS_OUT_W = 5;

	// Refresh timeout after reset, in milliseconds
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd1000;

	// Fixed-point shift used for the slot-to-group reciprocal
	localparam int unsigned RECIP_SHIFT = 12;

	// Entries of the packet queue between front and back
	localparam int unsigned QUEUE_DEPTH = 2;

	typedef enum logic {
		OP_DATA = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef struct packed {
		op_t                operation;
		logic [SLOT_W-1:0]  slot_index;
		logic [LEVEL_W-1:0] slot_value;
	} in_item_t;

	typedef struct packed {
		logic [LEVEL_W-1:0]   packet_byte;
		logic [POS_OUT_W-1:0] byte_position;
		logic                 packet_last;
	} out_item_t;

endpackage

>>> hdl/dgp_stream_if.sv
// Valid/ready stream channel with a typed payload.
// Payload types come from dgp_pkg.
`timescale 1ns / 1ps

interface dgp_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/dgp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module dgp_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 512,
	localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read; hold the last word when no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/dgp_front.sv
// Front end: accepts slot bytes and ticks, tracks the shadow levels and
// decides which groups go out. Uses dgp_pkg, dgp_stream_if and dgp_ram.
`timescale 1ns / 1ps
`include "dmx_delta_group_packetizer_assert.svh"

module dgp_front #(
	parameter int unsigned GROUP_BYTES = dgp_pkg::GROUP_BYTES_DEF,
	parameter int unsigned GROUP_COUNT = dgp_pkg::GROUP_COUNT_DEF,
	localparam int unsigned PKT_W = dgp_pkg::GROUP_OUT_W + dgp_pkg::SEQ_W
		+ GROUP_BYTES * dgp_pkg::LEVEL_W
) (
	input  logic                            clk,
	input  logic                            arst_n,
	dgp_stream_if.sink                      items,
	input  logic                            cfg_wr_en,
	input  logic [dgp_pkg::TIMEOUT_W-1:0]   cfg_wr_data,
	output logic                            push_valid,
	input  logic                            push_ready,
	output logic [PKT_W-1:0]                push_data
);

	localparam int unsigned SLOT_W     = dgp_pkg::SLOT_W;
	localparam int unsigned LEVEL_W    = dgp_pkg::LEVEL_W;
	localparam int unsigned MS_W       = dgp_pkg::MS_W;
	localparam int unsigned SEQ_W      = dgp_pkg::SEQ_W;
	localparam int unsigned SLOT_TOTAL = GROUP_BYTES * GROUP_COUNT;
	localparam int unsigned SLOT_SPAN  = 2 ** SLOT_W;
	localparam int unsigned SHADOW_DEPTH = (SLOT_TOTAL < SLOT_SPAN) ? SLOT_TOTAL : SLOT_SPAN;
	localparam int unsigned ADDR_W = (SHADOW_DEPTH > 1) ? $clog2(SHADOW_DEPTH) : 1;
	localparam int unsigned POS_W  = (GROUP_BYTES > 1) ? $clog2(GROUP_BYTES) : 1;
	localparam int unsigned GRP_W  = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
	localparam int unsigned RECIP_W = dgp_pkg::RECIP_SHIFT + 1;
	localparam int unsigned PROD_W  = SLOT_W + RECIP_W;
	localparam int unsigned MUL_W   = SLOT_W + 6;
	localparam int unsigned DATA_W  = GROUP_BYTES * LEVEL_W;
	localparam logic [RECIP_W-1:0] RECIP_C =
		RECIP_W'((2 ** dgp_pkg::RECIP_SHIFT) / GROUP_BYTES);
	localparam logic [MUL_W-1:0]  GB_C      = MUL_W'(GROUP_BYTES);
	localparam logic [POS_W-1:0]  POS_LAST  = POS_W'(GROUP_BYTES - 1);
	localparam logic [ADDR_W-1:0] CLR_LAST  = ADDR_W'(SHADOW_DEPTH - 1);

	// Accept side
	logic                in_fire;
	logic                in_range;
	logic [PROD_W-1:0]   prod;

	// Stage 1 registers
	logic                valid_s1;
	dgp_pkg::op_t        op_s1;
	logic [SLOT_W-1:0]   slot_s1;
	logic [LEVEL_W-1:0]  level_s1;
	logic [SLOT_W-1:0]   qest_s1;
	logic                range_s1;
	logic                byp_hit_s1;
	logic [LEVEL_W-1:0]  byp_level_s1;

	// Stage 1 logic
	logic [MUL_W-1:0]    qd;
	logic [MUL_W-1:0]    rem_raw;
	logic [MUL_W-1:0]    rem_adj;
	logic [SLOT_W-1:0]   grp_full;
	logic [GRP_W-1:0]    grp;
	logic [POS_W-1:0]    pos;
	logic [LEVEL_W-1:0]  shadow_rd;
	logic [LEVEL_W-1:0]  shadow_old;
	logic                data_s1;
	logic                differ;
	logic                changed_next;
	logic                last_pos;
	logic                timed_out;
	logic                send;
	logic                advance_s1;
	logic                fire_s1;
	logic [DATA_W-1:0]   snap;

	// State
	logic                        clr_busy_q;
	logic [ADDR_W-1:0]           clr_cnt_q;
	logic [dgp_pkg::TIMEOUT_W-1:0] timeout_q;
	logic [MS_W-1:0]             ms_q;
	logic [SEQ_W-1:0]            seq_q;
	logic                        changed_q;
	logic [LEVEL_W-1:0]          gbuf_q [GROUP_BYTES];

	// Shadow memory ports
	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [LEVEL_W-1:0]  ram_wdata;

	// Accept: estimate the group by reciprocal multiply
	assign in_fire  = items.valid && items.ready;
	assign in_range = 32'(items.data.slot_index) < SLOT_TOTAL;
	assign prod     = PROD_W'(items.data.slot_index) * PROD_W'(RECIP_C);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance_s1) begin
			valid_s1 <= in_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1        <= items.data.operation;
			slot_s1      <= items.data.slot_index;
			level_s1     <= items.data.slot_value;
			qest_s1      <= prod[dgp_pkg::RECIP_SHIFT +: SLOT_W];
			range_s1     <= in_range;
			byp_hit_s1   <= fire_s1 && data_s1 && differ
				&& (slot_s1 == items.data.slot_index);
			byp_level_s1 <= level_s1;
		end
	end

	// Stage 1: correct the group estimate and split off the position
	always_comb begin
		qd      = MUL_W'(qest_s1) * GB_C;
		rem_raw = MUL_W'(slot_s1) - qd;
		if (rem_raw >= GB_C) begin
			rem_adj  = rem_raw - GB_C;
			grp_full = qest_s1 + SLOT_W'(1);
		end else begin
			rem_adj  = rem_raw;
			grp_full = qest_s1;
		end
		pos = POS_W'(rem_adj);
		grp = GRP_W'(grp_full);
	end

	// Stage 1: compare against the shadow and take the send decision
	assign shadow_old   = byp_hit_s1 ? byp_level_s1 : shadow_rd;
	assign data_s1      = valid_s1 && (op_s1 == dgp_pkg::OP_DATA) && range_s1;
	assign differ       = shadow_old != level_s1;
	assign changed_next = ((pos != '0) && changed_q) || differ;
	assign last_pos     = pos == POS_LAST;
	assign timed_out    = ms_q > MS_W'(timeout_q);
	assign send         = data_s1 && last_pos && (changed_next || timed_out);
	assign advance_s1   = !valid_s1 || !send || push_ready;
	assign fire_s1      = valid_s1 && advance_s1;
	assign items.ready  = !clr_busy_q && advance_s1;

	// Snapshot the group with the current byte merged in
	always_comb begin
		for (int i = 0; i < GROUP_BYTES; i++) begin
			snap[i*LEVEL_W +: LEVEL_W] = (pos == POS_W'(i)) ? level_s1 : gbuf_q[i];
		end
	end

	assign push_valid = send;
	assign push_data  = {dgp_pkg::GROUP_OUT_W'(grp), seq_q, snap};

	// Shadow memory: clearing pass after reset, then change updates
	assign ram_we    = clr_busy_q || (fire_s1 && data_s1 && differ);
	assign ram_waddr = clr_busy_q ? clr_cnt_q : slot_s1[ADDR_W-1:0];
	assign ram_wdata = clr_busy_q ? '0 : level_s1;

	dgp_ram #(
		.WIDTH (LEVEL_W),
		.DEPTH (SHADOW_DEPTH)
	) u_shadow (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (in_fire),
		.raddr (items.data.slot_index[ADDR_W-1:0]),
		.rdata (shadow_rd)
	);

	// Advance the clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
			if (clr_cnt_q == CLR_LAST) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= dgp_pkg::TIMEOUT_RST;
		end else if (cfg_wr_en) begin
			timeout_q <= cfg_wr_data;
		end
	end

	// Elapsed time, sequence count and change flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ms_q      <= '0;
			seq_q     <= '0;
			changed_q <= 1'b0;
		end else if (fire_s1) begin
			if (send) begin
				ms_q  <= '0;
				seq_q <= seq_q + SEQ_W'(1);
			end else if ((op_s1 == dgp_pkg::OP_TICK) && (ms_q != '1)) begin
				ms_q <= ms_q + MS_W'(1);
			end
			if (data_s1) begin
				changed_q <= changed_next;
			end
		end
	end

	// Store the byte in the live group buffer
	always_ff @(posedge clk) begin
		if (fire_s1 && data_s1) begin
			gbuf_q[pos] <= level_s1;
		end
	end

	`DGP_ASSERT_NXT(a_send_clears_ms, clk, arst_n, push_valid && push_ready, ms_q == '0)
	`DGP_ASSERT_IMP(a_no_accept_in_clear, clk, arst_n, clr_busy_q, !items.ready)
	`DGP_ASSERT_IMP(a_send_at_last_pos, clk, arst_n, push_valid, last_pos && data_s1)

endmodule

>>> hdl/dgp_queue.sv
// Short packet queue between the front and back ends.
// Uses dgp_pkg for its default depth.
`timescale 1ns / 1ps

module dgp_queue #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = dgp_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push_fire;
	logic             pop_fire;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = entry_q[rd_ptr_q];
	assign push_fire  = push_valid && push_ready;
	assign pop_fire   = pop_valid && pop_ready;

	// Store pushed packets
	always_ff @(posedge clk) begin
		if (push_fire) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_fire) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop_fire) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push_fire && !pop_fire) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop_fire && !push_fire) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

>>> hdl/dgp_back.sv
// Back end: walks one queued packet out a beat at a time through an
// output register. Uses dgp_pkg and dgp_stream_if.
`timescale 1ns / 1ps
`include "dmx_delta_group_packetizer_assert.svh"

module dgp_back #(
	parameter int unsigned GROUP_BYTES = dgp_pkg::GROUP_BYTES_DEF,
	localparam int unsigned PKT_W = dgp_pkg::GROUP_OUT_W + dgp_pkg::SEQ_W
		+ GROUP_BYTES * dgp_pkg::LEVEL_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pop_valid,
	output logic             pop_ready,
	input  logic [PKT_W-1:0] pop_data,
	dgp_stream_if.source     packets
);

	localparam int unsigned LEVEL_W = dgp_pkg::LEVEL_W;
	localparam int unsigned DATA_W  = GROUP_BYTES * LEVEL_W;
	localparam int unsigned CNT_W   = $clog2(GROUP_BYTES + 2);
	localparam int unsigned POS_W   = (GROUP_BYTES > 1) ? $clog2(GROUP_BYTES) : 1;
	localparam logic [CNT_W-1:0] CNT_GROUP = CNT_W'(0);
	localparam logic [CNT_W-1:0] CNT_SEQ   = CNT_W'(1);
	localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(GROUP_BYTES + 1);

	logic [CNT_W-1:0]      cnt_q;
	logic                  out_vld_q;
	dgp_pkg::out_item_t    out_q;
	logic                  load;
	logic                  at_last;
	logic [POS_W-1:0]      idx;
	logic [LEVEL_W-1:0]    beat_byte;

	assign load      = pop_valid && (!out_vld_q || packets.ready);
	assign at_last   = cnt_q == CNT_LAST;
	assign pop_ready = load && at_last;
	assign idx       = POS_W'(cnt_q - CNT_W'(2));

	// Select the byte for the current position
	always_comb begin
		unique case (cnt_q)
			CNT_GROUP: beat_byte = pop_data[DATA_W + dgp_pkg::SEQ_W +: LEVEL_W];
			CNT_SEQ:   beat_byte = pop_data[DATA_W +: LEVEL_W];
			default:   beat_byte = pop_data[32'(idx) * LEVEL_W +: LEVEL_W];
		endcase
	end

	// Advance the position within the packet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (load) begin
				cnt_q     <= at_last ? '0 : cnt_q + CNT_W'(1);
				out_vld_q <= 1'b1;
			end else if (packets.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Hold the output beat until taken
	always_ff @(posedge clk) begin
		if (load) begin
			out_q.packet_byte   <= beat_byte;
			out_q.byte_position <= dgp_pkg::POS_OUT_W'(cnt_q);
			out_q.packet_last   <= at_last;
		end
	end

	assign packets.valid = out_vld_q;
	assign packets.data  = out_q;

	`DGP_ASSERT_NXT(a_pop_gives_last, clk, arst_n, pop_ready, packets.valid && packets.data.packet_last)
	`DGP_ASSERT_IMP(a_burst_keeps_head, clk, arst_n, packets.valid && packets.ready && !packets.data.packet_last, pop_valid)
	`DGP_ASSERT_IMP(a_last_position, clk, arst_n, packets.valid && packets.data.packet_last, packets.data.byte_position == dgp_pkg::POS_OUT_W'(GROUP_BYTES + 1))

endmodule

>>> hdl/dmx_delta_group_packetizer.sv
// DMX delta group packetizer top level: one input item per cycle while items.ready.
// A group that goes out passes from the stage-1 register through the packet queue
// to the back end's output register, then streams GROUP_BYTES+2 beats; a 2-packet
// queue absorbs bursts. The back end gives one beat per cycle while packets.ready.
// Reset clears all control state, then sweeps the shadow memory to zero,
// one entry per cycle (512 entries by default), with input held off meanwhile.
`timescale 1ns / 1ps

module dmx_delta_group_packetizer #(
	parameter int unsigned GROUP_BYTES = dgp_pkg::GROUP_BYTES_DEF,
	parameter int unsigned GROUP_COUNT = dgp_pkg::GROUP_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	dgp_stream_if.sink                    items,
	dgp_stream_if.source                  packets,
	input  logic                          cfg_wr_en,
	input  logic [dgp_pkg::TIMEOUT_W-1:0] cfg_wr_data
);

	localparam int unsigned PKT_W = dgp_pkg::GROUP_OUT_W + dgp_pkg::SEQ_W
		+ GROUP_BYTES * dgp_pkg::LEVEL_W;

	logic             push_valid;
	logic             push_ready;
	logic [PKT_W-1:0] push_data;
	logic             pop_valid;
	logic             pop_ready;
	logic [PKT_W-1:0] pop_data;

	// Classify items and decide sends
	dgp_front #(
		.GROUP_BYTES (GROUP_BYTES),
		.GROUP_COUNT (GROUP_COUNT)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.items       (items),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_data   (push_data)
	);

	// Decouple decision from emission
	dgp_queue #(
		.WIDTH (PKT_W),
		.DEPTH (dgp_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// Stream packets out
	dgp_back #(
		.GROUP_BYTES (GROUP_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.packets   (packets)
	);

endmodule
